/* src/ccbc_pkg.sv */
// Shared constants, mode codes, register indexes and control structs
// for the color centroid background classifier. No dependencies.
`default_nettype none

package ccbc_pkg;

  localparam int MODE_W  = 3;
  localparam int CHAN_W  = 8;
  localparam int CENT_W  = 16;
  localparam int SUM_W   = 28;
  localparam int CNT_W   = 21;
  localparam int DIST_W  = 34;
  localparam int IDX_W   = 20;
  localparam int SQ_W    = 2 * CENT_W;
  localparam int NCHAN   = 3;
  localparam int CH_W    = 2;
  localparam int REGI_W  = 2;

  localparam int DIV_N     = SUM_W + CHAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  localparam logic [MODE_W-1:0] MODE_ACC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOAD = 3'd4;

  localparam logic [REGI_W-1:0] REG_GREEN  = 2'd0;
  localparam logic [REGI_W-1:0] REG_BLUE   = 2'd1;
  localparam logic [REGI_W-1:0] REG_RED    = 2'd2;
  localparam logic [REGI_W-1:0] REG_THRESH = 2'd3;

  localparam logic [DIST_W-1:0] TH_RESET = 34'd16777216;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [CENT_W-1:0] CENT_MAX = '1;

  localparam longint unsigned MAX_PIXELS = 64'd1048576;
  localparam longint unsigned CNT_FULL   = (64'd1 << CNT_W) - 64'd1;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
      CNT_W'((MAX_PIXELS < CNT_FULL) ? MAX_PIXELS : CNT_FULL);

  typedef struct packed {
    logic            idle;
    logic            capture;
    logic            div_start;
    logic            div_wr;
    logic            sq_en;
    logic            eval_en;
    logic [CH_W-1:0] ch;
  } ccbc_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [MODE_W-1:0] in_mode;
    logic              cnt_gt1;
    logic              div_done;
    logic              out_busy;
  } ccbc_sts_t;

endpackage

`default_nettype wire

/* src/ccbc_in_if.sv */
// Input pixel channel: valid/ready handshake with the pixel word.
// Depends on ccbc_pkg.
`default_nettype none

interface ccbc_in_if import ccbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] red;
  logic [IDX_W-1:0]  pixel_index;

  modport source (output valid, mode, green, blue, red, pixel_index, input ready);
  modport sink (input valid, mode, green, blue, red, pixel_index, output ready);
endinterface

`default_nettype wire

/* src/ccbc_out_if.sv */
// Result channel: valid/ready handshake with the result word.
// Depends on ccbc_pkg.
`default_nettype none

interface ccbc_out_if import ccbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mask_bit;
  logic [IDX_W-1:0]  index_out;
  logic [DIST_W-1:0] moved_dist_sq;

  modport source (output valid, mask_bit, index_out, moved_dist_sq, input ready);
  modport sink (input valid, mask_bit, index_out, moved_dist_sq, output ready);
endinterface

`default_nettype wire

/* src/ccbc_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on ccbc_pkg.
`default_nettype none

interface ccbc_cfg_if import ccbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REGI_W-1:0] reg_index;
  logic [DIST_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* src/ccbc_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean update.
// Depends on ccbc_pkg.
`default_nettype none

module ccbc_div import ccbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_N-1:0]  dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [DIV_N-1:0]       quot
);

  logic [CNT_W-1:0]     rem_r;
  logic [DIV_N-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       shifted;
  logic                 ge;
  logic [CNT_W:0]       diff;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_N-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r <= {quo_r[DIV_N-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

  a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r) else $error("divider did not start");
  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= DIV_CNT_W'(DIV_N - 1)) else $error("divider step overrun");

endmodule

`default_nettype wire

/* src/ccbc_datapath.sv */
// Datapath: configuration registers, centroid, sums, count, squared
// distance unit, shared divider and result register. Uses ccbc_pkg, ccbc_div.
`default_nettype none

module ccbc_datapath import ccbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ccbc_in_if.sink         in_chan,
  ccbc_out_if.source      out_chan,
  ccbc_cfg_if.sink        cfg_chan,
  input  wire ccbc_cmd_t  cmd,
  output ccbc_sts_t       sts
);

  logic [CENT_W-1:0] init_r [NCHAN];
  logic [DIST_W-1:0] th_r;
  logic [CENT_W-1:0] cent_r [NCHAN];
  logic [CENT_W-1:0] newc_r [NCHAN];
  logic [SUM_W-1:0]  sum_r [NCHAN];
  logic [CNT_W-1:0]  cnt_r;
  logic [MODE_W-1:0] mode_r;
  logic [CHAN_W-1:0] pix_r [NCHAN];
  logic [IDX_W-1:0]  idx_r;
  logic [SQ_W-1:0]   sq_r [NCHAN];
  logic              out_valid_r;
  logic              out_mask_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_moved_r;

  logic [CENT_W-1:0] op_a [NCHAN];
  logic [CENT_W-1:0] op_b [NCHAN];
  logic [CENT_W-1:0] absd [NCHAN];
  logic [SQ_W-1:0]   sq_nxt [NCHAN];
  logic [SUM_W-1:0]  sum_nxt [NCHAN];
  logic [SUM_W:0]    sum_wide [NCHAN];
  logic [DIST_W-1:0] dsum;
  logic              near_bg;
  logic              div_done;
  logic [DIV_N-1:0]  quot;
  logic [CENT_W-1:0] quot_sat;
  logic              out_busy;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = cmd.idle;

  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      if (mode_r == MODE_UPD) begin
        op_a[i] = cent_r[i];
        op_b[i] = newc_r[i];
      end else begin
        op_a[i] = {pix_r[i], 8'h00};
        op_b[i] = cent_r[i];
      end
      absd[i]     = (op_a[i] >= op_b[i]) ? op_a[i] - op_b[i] : op_b[i] - op_a[i];
      sq_nxt[i]   = absd[i] * absd[i];
      sum_wide[i] = {1'b0, sum_r[i]} + {{(SUM_W + 1 - CHAN_W){1'b0}}, pix_r[i]};
      sum_nxt[i]  = sum_wide[i][SUM_W] ? SUM_MAX : sum_wide[i][SUM_W-1:0];
    end
    dsum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
    near_bg = dsum <= th_r;
  end

  ccbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_r[cmd.ch], 8'h00}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quot     (quot)
  );

  assign quot_sat = (|quot[DIV_N-1:CENT_W]) ? CENT_MAX : quot[CENT_W-1:0];
  assign out_busy = out_valid_r && !out_chan.ready;

  always_comb begin
    sts.in_valid = in_chan.valid;
    sts.in_mode  = in_chan.mode;
    sts.cnt_gt1  = cnt_r > CNT_W'(1);
    sts.div_done = div_done;
    sts.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCHAN; i++) begin
        init_r[i] <= '0;
        cent_r[i] <= '0;
        sum_r[i]  <= '0;
      end
      th_r        <= TH_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.reg_index)
          REG_GREEN:  init_r[0] <= cfg_chan.wdata[CENT_W-1:0];
          REG_BLUE:   init_r[1] <= cfg_chan.wdata[CENT_W-1:0];
          REG_RED:    init_r[2] <= cfg_chan.wdata[CENT_W-1:0];
          REG_THRESH: th_r      <= cfg_chan.wdata;
          default: begin
          end
        endcase
      end
      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.eval_en) begin
        out_valid_r <= 1'b1;
        case (mode_r)
          MODE_ACC: begin
            if (near_bg) begin
              for (int i = 0; i < NCHAN; i++) begin
                sum_r[i] <= sum_nxt[i];
              end
              if (cnt_r < CNT_LIMIT) begin
                cnt_r <= cnt_r + 1'b1;
              end
            end
          end
          MODE_UPD: begin
            for (int i = 0; i < NCHAN; i++) begin
              cent_r[i] <= newc_r[i];
            end
          end
          MODE_CLR: begin
            for (int i = 0; i < NCHAN; i++) begin
              sum_r[i] <= '0;
            end
            cnt_r <= '0;
          end
          MODE_LOAD: begin
            for (int i = 0; i < NCHAN; i++) begin
              cent_r[i] <= init_r[i];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_chan.mode;
      pix_r[0] <= in_chan.green;
      pix_r[1] <= in_chan.blue;
      pix_r[2] <= in_chan.red;
      idx_r    <= in_chan.pixel_index;
      for (int i = 0; i < NCHAN; i++) begin
        newc_r[i] <= cent_r[i];
      end
    end
    if (cmd.div_wr) begin
      newc_r[cmd.ch] <= quot_sat;
    end
    if (cmd.sq_en) begin
      for (int i = 0; i < NCHAN; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
    if (cmd.eval_en) begin
      out_idx_r   <= idx_r;
      out_mask_r  <= ((mode_r == MODE_ACC) && near_bg) ||
                     ((mode_r == MODE_CLS) && !(dsum < th_r));
      out_moved_r <= (mode_r == MODE_UPD) ? dsum : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.mask_bit      = out_mask_r;
  assign out_chan.index_out     = out_idx_r;
  assign out_chan.moved_dist_sq = out_moved_r;

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LIMIT) else $error("accepted count above its limit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval_en |-> !out_busy) else $error("result written over a pending word");
  a_moved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval_en && (mode_r != MODE_UPD) |=> out_moved_r == '0)
    else $error("moved distance nonzero outside update mean");

endmodule

`default_nettype wire

/* src/ccbc_ctrl.sv */
// Controller state machine: sequences capture, divisions, distance
// and evaluation. Depends on ccbc_pkg.
`default_nettype none

module ccbc_ctrl import ccbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ccbc_sts_t  sts,
  output ccbc_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT  = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;

  logic [2:0]      state_r;
  logic [2:0]      state_nxt;
  logic [CH_W-1:0] ch_r;
  logic [CH_W-1:0] ch_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cmd           = '0;
    cmd.ch        = ch_r;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          ch_nxt      = '0;
          if ((sts.in_mode == MODE_UPD) && sts.cnt_gt1) begin
            state_nxt = S_DSTART;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_wr = 1'b1;
          if (ch_r == CH_W'(NCHAN - 1)) begin
            state_nxt = S_SQ;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.out_busy) begin
          cmd.eval_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_div_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.cnt_gt1) else $error("division started with count below two");
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.div_start, cmd.div_wr, cmd.sq_en, cmd.eval_en}))
    else $error("conflicting datapath commands");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWAIT) && !sts.div_done |=> state_r == S_DWAIT)
    else $error("left division wait without done");

endmodule

`default_nettype wire

/* src/color_centroid_background_classifier_unit.sv */
// Accumulate, classify, clear and load words go through the capture, square and evaluate
// steps, and evaluate waits while the output register holds an untaken word.
// The next word is accepted only after evaluate. Update mean with a count above one runs
// the 36-step divider once per channel first. Results wait in an output register.
// Reset (rst_n, synchronous) clears centroid, sums, count and registers to their defaults.
`default_nettype none

module color_centroid_background_classifier_unit import ccbc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccbc_in_if.sink    in_chan,
  ccbc_out_if.source out_chan,
  ccbc_cfg_if.sink   cfg_chan
);

  ccbc_cmd_t cmd;
  ccbc_sts_t sts;

  ccbc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ccbc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

/* verif/color_centroid_background_classifier_unit_tb.sv */
// Self-checking testbench for color_centroid_background_classifier_unit: pixel words are
// queued by the stimulus process, driven with random gaps and checked against a predictor.
// Depends on ccbc_pkg and the ccbc_in_if, ccbc_out_if and ccbc_cfg_if interfaces.
module color_centroid_background_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccbc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [DIST_W-1:0] TH_WIDEST    = 34'd12784435200;
  localparam logic [DIST_W-1:0] TH_ALL_ONES  = '1;
  localparam int                SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] red;
    logic [IDX_W-1:0]  pixel_index;
  } pixel_word_t;

  typedef struct packed {
    logic              mask_bit;
    logic [IDX_W-1:0]  index_out;
    logic [DIST_W-1:0] moved_dist_sq;
  } label_word_t;

  logic clk;
  logic rst_n;

  ccbc_in_if  in_chan ();
  ccbc_out_if out_chan ();
  ccbc_cfg_if cfg_chan ();

  color_centroid_background_classifier_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor state; channel 0 is green, 1 blue, 2 red.
  logic [NCHAN-1:0][CENT_W-1:0] bg_centroid;
  logic [NCHAN-1:0][SUM_W-1:0]  bg_sums;
  logic [CNT_W-1:0]             bg_count;
  logic [NCHAN-1:0][CENT_W-1:0] init_color;
  logic [DIST_W-1:0]            thresh_sq;

  pixel_word_t pending_pixels[$];
  label_word_t expected_labels[$];
  pixel_word_t cur_word;
  label_word_t want;
  int          mismatch_count;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          gap_tab[4]   = '{0, 51, 0, 13};
  int          stall_tab[4] = '{0, 0, 51, 13};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [DIST_W-1:0] color_dist_sq(input logic [NCHAN-1:0][CENT_W-1:0] a,
                                                      input logic [NCHAN-1:0][CENT_W-1:0] b);
    logic [DIST_W-1:0] acc;
    logic [CENT_W-1:0] d;
    acc = '0;
    for (int i = 0; i < NCHAN; i++) begin
      d = (a[i] >= b[i]) ? a[i] - b[i] : b[i] - a[i];
      acc = acc + DIST_W'(d) * DIST_W'(d);
    end
    return acc;
  endfunction

  function automatic label_word_t predict_label(input pixel_word_t w);
    logic [NCHAN-1:0][CHAN_W-1:0] px8;
    logic [NCHAN-1:0][CENT_W-1:0] pix;
    logic [NCHAN-1:0][CENT_W-1:0] old_c;
    logic [DIST_W-1:0]            d;
    logic [SUM_W:0]               s;
    logic [SUM_W+CHAN_W-1:0]      q;
    label_word_t                  r;
    px8 = {w.red, w.blue, w.green};
    for (int i = 0; i < NCHAN; i++) pix[i] = {px8[i], 8'h00};
    r.mask_bit = 1'b0;
    r.index_out = w.pixel_index;
    r.moved_dist_sq = '0;
    d = color_dist_sq(pix, bg_centroid);
    case (w.mode)
      MODE_ACC: begin
        if (d <= thresh_sq) begin
          for (int i = 0; i < NCHAN; i++) begin
            s = bg_sums[i] + px8[i];
            bg_sums[i] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
          end
          if (bg_count < CNT_LIMIT) bg_count = bg_count + 1'b1;
          r.mask_bit = 1'b1;
        end
      end
      MODE_CLS: r.mask_bit = (d >= thresh_sq);
      MODE_UPD: begin
        old_c = bg_centroid;
        if (bg_count > 1) begin
          for (int i = 0; i < NCHAN; i++) begin
            q = {bg_sums[i], 8'h00} / bg_count;
            bg_centroid[i] = (q > CENT_MAX) ? CENT_MAX : q[CENT_W-1:0];
          end
        end
        r.moved_dist_sq = color_dist_sq(old_c, bg_centroid);
      end
      MODE_CLR: begin
        bg_sums = '0;
        bg_count = '0;
      end
      MODE_LOAD: bg_centroid = init_color;
      default: ;
    endcase
    return r;
  endfunction

  // Pixel driver: presents queued words, holds each until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) expected_labels.push_back(predict_label(cur_word));
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          cur_word = pending_pixels.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.mode        <= cur_word.mode;
          in_chan.green       <= cur_word.green;
          in_chan.blue        <= cur_word.blue;
          in_chan.red         <= cur_word.red;
          in_chan.pixel_index <= cur_word.pixel_index;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_labels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: index %05h mask %0b moved %0d",
                     out_chan.index_out, out_chan.mask_bit, out_chan.moved_dist_sq);
        end else begin
          want = expected_labels.pop_front();
          if (out_chan.mask_bit !== want.mask_bit || out_chan.index_out !== want.index_out ||
              out_chan.moved_dist_sq !== want.moved_dist_sq) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected index %05h mask %0b moved %0d, got index %05h mask %0b moved %0d",
                       want.index_out, want.mask_bit, want.moved_dist_sq,
                       out_chan.index_out, out_chan.mask_bit, out_chan.moved_dist_sq);
          end
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void queue_pixel(input logic [MODE_W-1:0] m, input logic [CHAN_W-1:0] g,
                                      input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] r,
                                      input logic [IDX_W-1:0] idx);
    pixel_word_t w;
    w.mode = m;
    w.green = g;
    w.blue = b;
    w.red = r;
    w.pixel_index = idx;
    pending_pixels.push_back(w);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan(input int base, input int spread, input bit far);
    int v;
    if (far) return CHAN_W'($urandom_range(0, 255));
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic logic [CENT_W-1:0] pick_color();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CENT_MAX;
      default: return CENT_W'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (pending_pixels.size() > 0 || in_chan.valid || expected_labels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [DIST_W-1:0] val);
    @(posedge clk);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wdata     <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_GREEN:  init_color[0] = val[CENT_W-1:0];
      REG_BLUE:   init_color[1] = val[CENT_W-1:0];
      REG_RED:    init_color[2] = val[CENT_W-1:0];
      REG_THRESH: thresh_sq = val;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic program_scene(input int n);
    logic [DIST_W-1:0] th;
    write_reg(REG_GREEN, DIST_W'(pick_color()));
    write_reg(REG_BLUE, DIST_W'(pick_color()));
    write_reg(REG_RED, DIST_W'(pick_color()));
    case (n % 7)
      0: th = TH_RESET;
      1: th = '0;
      2: th = 34'd1;
      3: th = TH_WIDEST;
      4: th = TH_ALL_ONES;
      5: th = DIST_W'($urandom_range(1, 1 << 27));
      default: th = DIST_W'({$urandom, $urandom});
    endcase
    write_reg(REG_THRESH, th);
  endtask

  // Mostly load / clear / accumulate / update / classify runs around the loaded
  // centroid, with some stray words of any mode mixed in.
  task automatic queue_scene(input int n_items);
    int added;
    int bg;
    int bb;
    int br;
    int spread;
    int k;
    bit far;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        bg = int'(init_color[0][15:8]) + int'($urandom_range(0, 6)) - 3;
        bb = int'(init_color[1][15:8]) + int'($urandom_range(0, 6)) - 3;
        br = int'(init_color[2][15:8]) + int'($urandom_range(0, 6)) - 3;
        spread = $urandom_range(0, 12);
        if ($urandom_range(0, 3) != 0) begin
          queue_pixel(MODE_LOAD, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                      IDX_W'($urandom));
          queue_pixel(MODE_CLR, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                      IDX_W'($urandom));
          added += 2;
        end
        k = $urandom_range(2, 12);
        repeat (k) begin
          far = ($urandom_range(0, 4) == 0);
          queue_pixel(MODE_ACC, pick_chan(bg, spread, far), pick_chan(bb, spread, far),
                      pick_chan(br, spread, far), IDX_W'($urandom));
        end
        queue_pixel(MODE_UPD, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                    IDX_W'($urandom));
        added += k + 1;
        k = $urandom_range(1, 6);
        repeat (k) begin
          far = ($urandom_range(0, 2) == 0);
          queue_pixel(MODE_CLS, pick_chan(bg, spread, far), pick_chan(bb, spread, far),
                      pick_chan(br, spread, far), IDX_W'($urandom));
        end
        added += k;
        if ($urandom_range(0, 3) == 0) begin
          queue_pixel(MODE_UPD, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                      IDX_W'($urandom));
          added++;
        end
      end else begin
        queue_pixel(MODE_W'($urandom_range(0, 7)), CHAN_W'($urandom), CHAN_W'($urandom),
                    CHAN_W'($urandom), IDX_W'($urandom));
        added++;
      end
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.mode = '0;
    in_chan.green = '0;
    in_chan.blue = '0;
    in_chan.red = '0;
    in_chan.pixel_index = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.reg_index = '0;
    cfg_chan.wdata = '0;
    cur_word = '0;
    bg_centroid = '0;
    bg_sums = '0;
    bg_count = '0;
    init_color = '0;
    thresh_sq = TH_RESET;
    mismatch_count = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: threshold equality on both compares, too few pixels, spare modes.
    queue_pixel(MODE_CLS, 8'd0, 8'd0, 8'd0, '0);
    queue_pixel(MODE_ACC, 8'd0, 8'd0, 8'd0, '1);
    queue_pixel(MODE_ACC, 8'd16, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_CLS, 8'd16, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_UPD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_UPD, 8'd255, 8'd255, 8'd255, IDX_W'($urandom));
    queue_pixel(MODE_ACC, 8'd255, 8'd255, 8'd255, IDX_W'($urandom));
    queue_pixel(MODE_CLR, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_UPD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_ACC, 8'd8, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_UPD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_SPARE_LO, 8'd255, 8'd255, 8'd255, '1);
    queue_pixel(MODE_SPARE_LO + 3'd1, 8'd1, 8'd2, 8'd3, IDX_W'($urandom));
    queue_pixel(MODE_SPARE_HI, 8'd0, 8'd0, 8'd0, '0);
    queue_pixel(MODE_LOAD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    drain();

    // Zero threshold: only an exact match is accepted, every pixel is an object.
    write_reg(REG_THRESH, '0);
    write_reg(REG_GREEN, 34'h08000);
    write_reg(REG_BLUE, 34'h04000);
    write_reg(REG_RED, 34'h00100);
    queue_pixel(MODE_LOAD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_ACC, 8'd128, 8'd64, 8'd1, IDX_W'($urandom));
    queue_pixel(MODE_ACC, 8'd128, 8'd64, 8'd2, IDX_W'($urandom));
    queue_pixel(MODE_CLS, 8'd128, 8'd64, 8'd1, IDX_W'($urandom));
    drain();

    // Widest threshold against the farthest pixel, then the largest centroid.
    write_reg(REG_THRESH, TH_WIDEST);
    write_reg(REG_GREEN, '0);
    write_reg(REG_BLUE, '0);
    write_reg(REG_RED, '0);
    queue_pixel(MODE_LOAD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_ACC, 8'd255, 8'd255, 8'd255, IDX_W'($urandom));
    queue_pixel(MODE_CLS, 8'd255, 8'd255, 8'd255, IDX_W'($urandom));
    queue_pixel(MODE_CLS, 8'd254, 8'd255, 8'd255, IDX_W'($urandom));
    drain();
    write_reg(REG_GREEN, 34'h0FFFF);
    write_reg(REG_BLUE, 34'h0FFFF);
    write_reg(REG_RED, 34'h0FFFF);
    queue_pixel(MODE_LOAD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_CLS, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));
    queue_pixel(MODE_UPD, 8'd0, 8'd0, 8'd0, IDX_W'($urandom));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_gap_pct <= gap_tab[ph];
      recv_stall_pct <= stall_tab[ph];
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        program_scene(ph * 4 + blk);
        if (ph == 2 && blk == 1) begin
          queue_scene(28);
          drain();
          queue_scene(28);
        end else begin
          queue_scene(56);
        end
      end
    end
    drain();

    if (mismatch_count == 0 && expected_labels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
